[rtl/core/hmb_pkg.sv]
// ----------------------------------------------------------------------------
// hmb_pkg: shared constants and types for the height map binning block
// Geometry, fixed-point factors, and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package hmb_pkg;

  // request kinds on the input channel
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // image and grid geometry
  localparam int IMAGE_W   = 640;
  localparam int IMAGE_H   = 480;
  localparam int GRID_W    = 128;
  localparam int GRID_H    = 128;
  localparam int CELL_AW   = 7;                  // bits of one grid coordinate
  localparam int MAP_AW    = 2 * CELL_AW;        // cell address bits
  localparam int MAP_CELLS = GRID_W * GRID_H;
  localparam int ROW_MID   = IMAGE_H / 2;
  localparam int COL_MID   = IMAGE_W / 2;
  localparam int GRID_MID  = GRID_H / 2;

  // 2*tan(0.675) in Q16
  localparam int KQ16      = 104913;

  // height: divide by 2*IMAGE_H*65536 = 15 * 2^22
  localparam int H_SHIFT   = 22;
  localparam int H_RECIP   = 71582789;           // ceil(2^30 / 15)
  localparam int H_RSHIFT  = 30;

  // lateral: divide by 2*IMAGE_W*65536*40 = 25 * 2^27
  localparam int S_SHIFT   = 27;
  localparam int S_ROUND   = (1 << S_SHIFT) - 1;
  localparam int S_DIV     = 25;
  localparam int S_RECIP   = 671089;             // ceil(2^24 / 25)
  localparam int S_RSHIFT  = 24;

  // forward: divide by 80 = 5 * 2^4, rounded up
  localparam int Y_DIV     = 80;
  localparam int Y_SHIFT   = 4;
  localparam int Y_RECIP   = 13108;              // ceil(2^16 / 5)
  localparam int Y_RSHIFT  = 16;

  localparam logic [15:0] HEIGHT_MAX = 16'hFFFF;

  // controller -> datapath
  typedef struct packed {
    logic cap;       // latch the accepted beat
    logic s1;        // first products
    logic s2;        // Q16 products, forward cell
    logic s3;        // height reciprocal, lateral rounding
    logic s4;        // height result, lateral reciprocal
    logic rd_pix;    // read target cell of the pixel
    logic wr_pix;    // max update of the pixel's cell
    logic rd_cell;   // read cell of a read request
    logic wr_zero;   // clear cell of a read request
    logic out_load;  // load output register
    logic clr_wr;    // clearing pass write
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_read;  // latched beat is a read request
    logic clr_last;  // clearing pass at last cell
  } sts_t;

endpackage

[rtl/core/hmb_if.sv]
// ----------------------------------------------------------------------------
// hmb_in_if / hmb_out_if: valid/ready channels of the height map binning block
// Request channel carries pixels and read requests; result channel heights.
// ----------------------------------------------------------------------------
interface hmb_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  pixel_column;
  logic [8:0]  pixel_row;
  logic [15:0] depth_mm;
  logic [6:0]  read_cell_x;
  logic [6:0]  read_cell_y;

  modport source (
    output valid, req_type, pixel_column, pixel_row, depth_mm, read_cell_x, read_cell_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, pixel_column, pixel_row, depth_mm, read_cell_x, read_cell_y,
    output ready
  );
endinterface

interface hmb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_height;

  modport source (output valid, cell_height, input ready);
  modport sink   (input valid, cell_height, output ready);
endinterface

[rtl/core/hmb_ctrl.sv]
// ----------------------------------------------------------------------------
// hmb_ctrl: sequencing state machine
// Clearing pass, pixel pipeline steps, read-and-clear, output register valid.
// ----------------------------------------------------------------------------
module hmb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  hmb_pkg::sts_t sts,
  output hmb_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_S1   = 4'd2;
  localparam logic [3:0] ST_S2   = 4'd3;
  localparam logic [3:0] ST_S3   = 4'd4;
  localparam logic [3:0] ST_S4   = 4'd5;
  localparam logic [3:0] ST_RDP  = 4'd6;
  localparam logic [3:0] ST_WR   = 4'd7;
  localparam logic [3:0] ST_RD   = 4'd8;
  localparam logic [3:0] ST_RES  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_S1;
        end
      end
      ST_S1: begin
        if (sts.req_read) begin
          state_nxt = ST_RD;
        end else begin
          cmd.s1    = 1'b1;
          state_nxt = ST_S2;
        end
      end
      ST_S2: begin
        cmd.s2    = 1'b1;
        state_nxt = ST_S3;
      end
      ST_S3: begin
        cmd.s3    = 1'b1;
        state_nxt = ST_S4;
      end
      ST_S4: begin
        cmd.s4    = 1'b1;
        state_nxt = ST_RDP;
      end
      ST_RDP: begin
        cmd.rd_pix = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        cmd.wr_pix = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RD: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = ST_RES;
      end
      ST_RES: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.wr_zero  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/hmb_datapath.sv]
// ----------------------------------------------------------------------------
// hmb_datapath: projection arithmetic and height map memory
// Staged multiplies with reciprocal division, one-port-write cell memory.
// ----------------------------------------------------------------------------
module hmb_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  hmb_pkg::cmd_t cmd,
  output hmb_pkg::sts_t sts,
  input  logic          in_req_type,
  input  logic [9:0]    in_pixel_column,
  input  logic [8:0]    in_pixel_row,
  input  logic [15:0]   in_depth_mm,
  input  logic [6:0]    in_read_cell_x,
  input  logic [6:0]    in_read_cell_y,
  output logic [15:0]   out_cell_height
);

  // captured beat
  logic        req_r;
  logic [9:0]  col_r;
  logic [8:0]  row_r;
  logic [15:0] dep_r;
  logic [6:0]  rx_r, ry_r;

  // stage registers
  logic        hpos_r, spos_r, hok_r;
  logic [25:0] hp1_r;
  logic [26:0] sp1_r;
  logic [26:0] y1_r;
  logic [42:0] hp2_r;
  logic [43:0] sp2_r;
  logic [6:0]  gy_r;
  logic [47:0] hx_r;
  logic [18:0] z_r;
  logic [15:0] h_r;
  logic [38:0] qs_r;
  logic [hmb_pkg::MAP_AW-1:0] pix_addr_r;
  logic [15:0] rd_data_r;
  logic [15:0] out_r;
  logic [hmb_pkg::MAP_AW-1:0] clr_cnt_r;

  logic [15:0] mem_r [hmb_pkg::MAP_CELLS];

  // stage 1
  logic [8:0]  row_ofs;
  logic [9:0]  hv;
  logic        spos_nxt;
  logic [10:0] sa;
  logic [16:0] dy;
  // stage 2
  logic [10:0] qy;
  logic [6:0]  gy_nxt;
  // stage 3
  logic [44:0] sr;
  logic [17:0] sy;
  logic [18:0] z_nxt;
  // stage 4
  logic [17:0] hq;
  // cell address
  logic [14:0] qx;
  logic [6:0]  gx;
  logic [hmb_pkg::MAP_AW-1:0] pix_addr, cell_addr;
  logic        cell_ok;
  // write port
  logic        wr_en;
  logic [hmb_pkg::MAP_AW-1:0] wr_addr;
  logic [15:0] wr_data;

  always_comb begin
    row_ofs  = row_r - 9'(hmb_pkg::ROW_MID);
    hv       = {row_ofs, 1'b0};
    spos_nxt = col_r < 10'(hmb_pkg::COL_MID);
    sa       = spos_nxt ? (11'(hmb_pkg::IMAGE_W) - {col_r, 1'b0})
                        : ({col_r, 1'b0} - 11'(hmb_pkg::IMAGE_W));
    dy       = 17'(dep_r) + 17'(hmb_pkg::Y_DIV - 1);

    qy       = y1_r[26:hmb_pkg::Y_RSHIFT];
    gy_nxt   = (qy >= 11'(hmb_pkg::GRID_W)) ? 7'd0 : 7'(11'(hmb_pkg::GRID_W) - qy);

    // ceil on the positive side, floor on the negative side
    sr       = spos_r ? (45'(sp2_r) + 45'(hmb_pkg::S_ROUND)) : 45'(sp2_r);
    sy       = sr[44:hmb_pkg::S_SHIFT];
    z_nxt    = spos_r ? (19'(sy) + 19'(hmb_pkg::S_DIV - 1)) : 19'(sy);

    hq       = hx_r[47:hmb_pkg::H_RSHIFT];

    qx = qs_r[38:hmb_pkg::S_RSHIFT];
    if (spos_r) begin
      gx = (qx >= 15'(hmb_pkg::GRID_MID)) ? 7'd0 : 7'(15'(hmb_pkg::GRID_MID) - qx);
    end else begin
      gx = (qx >= 15'(hmb_pkg::GRID_MID)) ? 7'(hmb_pkg::GRID_W - 1)
                                          : 7'(15'(hmb_pkg::GRID_MID) + qx);
    end
    // row-major, GRID_W is a power of two
    pix_addr  = {gy_r, gx};
    cell_addr = {ry_r, rx_r};
    cell_ok   = (8'(rx_r) < 8'(hmb_pkg::GRID_W)) && (8'(ry_r) < 8'(hmb_pkg::GRID_H));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_r;
    wr_data = 16'd0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.wr_pix) begin
      wr_en   = hok_r && (h_r > rd_data_r);
      wr_addr = pix_addr_r;
      wr_data = h_r;
    end else if (cmd.wr_zero) begin
      wr_en   = cell_ok;
      wr_addr = cell_addr;
    end
  end

  assign sts.req_read = (req_r == hmb_pkg::REQ_READ);
  assign sts.clr_last = (clr_cnt_r == hmb_pkg::MAP_AW'(hmb_pkg::MAP_CELLS - 1));
  assign out_cell_height = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_req_type;
      col_r <= in_pixel_column;
      row_r <= in_pixel_row;
      dep_r <= in_depth_mm;
      rx_r  <= in_read_cell_x;
      ry_r  <= in_read_cell_y;
    end
    if (cmd.s1) begin
      hpos_r <= row_r > 9'(hmb_pkg::ROW_MID);
      hp1_r  <= 26'(hv) * 26'(dep_r);
      spos_r <= spos_nxt;
      sp1_r  <= 27'(sa) * 27'(dep_r);
      y1_r   <= 27'(dy[16:hmb_pkg::Y_SHIFT]) * 27'(hmb_pkg::Y_RECIP);
    end
    if (cmd.s2) begin
      hp2_r <= 43'(hp1_r) * 43'(hmb_pkg::KQ16);
      sp2_r <= 44'(sp1_r) * 44'(hmb_pkg::KQ16);
      gy_r  <= gy_nxt;
    end
    if (cmd.s3) begin
      hx_r <= 48'(hp2_r[42:hmb_pkg::H_SHIFT]) * 48'(hmb_pkg::H_RECIP);
      z_r  <= z_nxt;
    end
    if (cmd.s4) begin
      h_r   <= (hq > 18'(hmb_pkg::HEIGHT_MAX)) ? hmb_pkg::HEIGHT_MAX : hq[15:0];
      hok_r <= hpos_r && (dep_r != 16'd0) && (hq != 18'd0);
      qs_r  <= 39'(z_r) * 39'(hmb_pkg::S_RECIP);
    end
    if (cmd.rd_pix) begin
      pix_addr_r <= pix_addr;
    end
    if (cmd.out_load) begin
      out_r <= cell_ok ? rd_data_r : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_pix) begin
      rd_data_r <= mem_r[pix_addr];
    end else if (cmd.rd_cell) begin
      rd_data_r <= mem_r[cell_addr];
    end
  end

endmodule

[rtl/core/depth_pixel_height_map_binning.sv]
// ----------------------------------------------------------------------------
// depth_pixel_height_map_binning: depth pixels to a max-height grid
// Projects depth pixels into a 128x128 height map; read requests drain cells.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 16384 cells (one cell
// per cycle) with in ready low. Then each beat on in_ch is either a depth
// pixel (req_type 0) or a read-and-clear of one cell (req_type 1). A pixel
// goes from its accept cycle through four steps of the multiply/reciprocal
// chain, one memory read and one max write-back, all on a single memory port;
// in ready comes back after the write-back. A read request goes through a
// memory read and a result step that waits for the output register to empty;
// it yields one cell_height beat on out_ch and leaves the cell at zero. Pixels
// give no result. Pixels with zero depth, at or above the image center row, or
// whose height floors to zero are dropped; cell indices clip at the grid edges
// and heights saturate at 65535 mm.
// ----------------------------------------------------------------------------
module depth_pixel_height_map_binning (
  input  logic clk,
  input  logic rst_n,
  hmb_in_if.sink    in_ch,
  hmb_out_if.source out_ch
);

  hmb_pkg::cmd_t cmd;
  hmb_pkg::sts_t sts;

  // sequencing: clear sweep, pixel steps, read-and-clear, output valid
  hmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, cell memory and output data register
  hmb_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_pixel_column (in_ch.pixel_column),
    .in_pixel_row    (in_ch.pixel_row),
    .in_depth_mm     (in_ch.depth_mm),
    .in_read_cell_x  (in_ch.read_cell_x),
    .in_read_cell_y  (in_ch.read_cell_y),
    .out_cell_height (out_ch.cell_height)
  );

`ifndef SYNTH
  // no beat taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> !in_ch.ready)
    else $error("input ready during clearing pass");

  // one item in flight: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second beat accepted while busy");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
    else $error("output register overwritten");

  // output only from a read request
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.req_read)
    else $error("result produced for a pixel beat");
`endif

endmodule
